// ----- hdl/dfr_pkg.sv -----
`default_nettype none

package dfr_pkg;

  // Header window default, queue depth, register reset
  localparam int unsigned HeaderWindow = 70;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned LevelW = $clog2(QueueDepth + 1);
  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam logic [7:0] PartCountReset = 8'd1;

  // Register indexes (byte address bit 2 selects the register)
  localparam logic [0:0] RegPartCount = 1'b0;

  // Literal lengths
  localparam logic [3:0] PreambleLen = 4'd14;
  localparam logic [3:0] HeadLen = 4'd9;
  localparam logic [3:0] ClLen = 4'd4;

  // Number limits, 36-bit wide to hold one decimal step of a 32-bit value
  localparam logic [35:0] TagMax = 36'h0_0000_FFFF;
  localparam logic [35:0] WordMax = 36'h0_FFFF_FFFF;

  // Audio stream tags
  localparam logic [15:0] AudioTagA = 16'd139;
  localparam logic [15:0] AudioTagB = 16'd140;

  // Delimiters
  localparam logic [7:0] ChDigit0 = "0";
  localparam logic [7:0] ChDigit9 = "9";
  localparam logic [7:0] ChDash = "-";
  localparam logic [7:0] ChQuote = "\"";
  localparam logic [7:0] ChSlash = "/";

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_PREAMBLE  = 3'd1,
    ERR_GRAMMAR   = 3'd2,
    ERR_TOO_LONG  = 3'd3,
    ERR_TRUNCATED = 3'd4,
    ERR_OVERFLOW  = 3'd5
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic        part_end;
    logic [15:0] track_tag;
    logic [31:0] chunk_index;
    logic        audio_flag;
    logic [31:0] payload_length;
    logic [7:0]  part_number;
    logic [7:0]  parts_found;
    err_e        error_code;
    logic        run_last;
  } res_t;

  // Results of one parsed word, pushed into the result queue together
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } res_push_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic              room_two;
    logic [LevelW-1:0] level;
  } q_stat_t;

  function automatic logic [7:0] preamble_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "S";
      4'd1:    c = "A";
      4'd2:    c = "B";
      4'd3:    c = "E";
      4'd4:    c = "R";
      4'd5:    c = "-";
      4'd6:    c = "S";
      4'd7:    c = "T";
      4'd8:    c = "A";
      4'd9:    c = "R";
      4'd10:   c = "T";
      4'd11:   c = "/";
      4'd12:   c = "/";
      4'd13:   c = "/";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] head_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "/";
      4'd1:    c = "/";
      4'd2:    c = "S";
      4'd3:    c = "P";
      4'd4:    c = "A";
      4'd5:    c = "R";
      4'd6:    c = "T";
      4'd7:    c = "-";
      4'd8:    c = "\"";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cl_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "-";
      4'd1:    c = "C";
      4'd2:    c = "L";
      4'd3:    c = "=";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/dfr_parser.sv -----
`default_nettype none

module dfr_parser #(
  parameter int unsigned HEADER_WINDOW = dfr_pkg::HeaderWindow
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              last_i,
  input  wire logic [7:0]        part_count_i,
  output dfr_pkg::res_push_t     push_o
);

  localparam int unsigned HbW = $clog2(HEADER_WINDOW + 1);

  typedef enum logic [3:0] {
    PH_PRE, PH_HLIT, PH_TAG, PH_CHUNK, PH_CLLIT, PH_LEN, PH_CLOSE, PH_PAY, PH_SKIP
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [3:0]     lit_q, lit_d;
  logic [HbW-1:0] hb_q, hb_d;
  logic [15:0]    tag_q, tag_d;
  logic [31:0]    chunk_q, chunk_d;
  logic [31:0]    len_q, len_d;
  logic [31:0]    left_q, left_d;
  logic [7:0]     pc_q, pc_d;
  logic           ds_q, ds_d;

  dfr_pkg::res_t  res_d [2];
  dfr_pkg::res_t  rr;
  logic [1:0]     n_d;
  dfr_pkg::err_e  err_d;

  logic [31:0]    acc_sel;
  logic [35:0]    acc_ext;
  logic [35:0]    prod;
  logic [35:0]    limit;
  logic           is_dig;
  logic           ovf;

  // One decimal step on the accumulator of the current number field
  always_comb begin
    case (phase_q)
      PH_TAG:   acc_sel = {16'd0, tag_q};
      PH_CHUNK: acc_sel = chunk_q;
      default:  acc_sel = len_q;
    endcase
    limit   = (phase_q == PH_TAG) ? dfr_pkg::TagMax : dfr_pkg::WordMax;
    acc_ext = {4'd0, acc_sel};
    is_dig  = (byte_i >= dfr_pkg::ChDigit0) && (byte_i <= dfr_pkg::ChDigit9);
    prod    = (acc_ext << 3) + (acc_ext << 1) + {32'd0, byte_i[3:0] - dfr_pkg::ChDigit0[3:0]};
    ovf     = prod > limit;
  end

  // Next state and results for the word in the input register
  always_comb begin
    phase_d = phase_q;
    lit_d   = lit_q;
    hb_d    = hb_q;
    tag_d   = tag_q;
    chunk_d = chunk_q;
    len_d   = len_q;
    left_d  = left_q;
    pc_d    = pc_q;
    ds_d    = ds_q;
    res_d[0] = '0;
    res_d[1] = '0;
    n_d     = 2'd0;
    err_d   = dfr_pkg::ERR_NONE;
    rr      = '0;

    if (phase_q == PH_PRE) begin
      if (lit_q == 4'd0 && part_count_i == 8'd0) begin
        // zero parts: report done at once
        rr.kind = dfr_pkg::KIND_DONE;
        rr.part_number = pc_q;
        res_d[n_d[0]] = rr;
        n_d = n_d + 2'd1;
        phase_d = PH_SKIP;
      end else if (lit_q >= dfr_pkg::PreambleLen || byte_i != dfr_pkg::preamble_char(lit_q)) begin
        err_d = dfr_pkg::ERR_PREAMBLE;
      end else begin
        lit_d = lit_q + 4'd1;
        if (lit_d == dfr_pkg::PreambleLen) begin
          phase_d = PH_HLIT;
          lit_d   = 4'd0;
          hb_d    = '0;
          tag_d   = '0;
          chunk_d = '0;
          len_d   = '0;
          ds_d    = 1'b0;
        end
      end
    end else if (phase_q == PH_PAY) begin
      // stream one payload word, close the part on its last word
      rr.kind = dfr_pkg::KIND_PAYLOAD;
      rr.data_byte = byte_i;
      rr.part_number = pc_q;
      left_d = left_q - 32'd1;
      if (left_d == 32'd0) begin
        rr.part_end = 1'b1;
        res_d[n_d[0]] = rr;
        n_d = n_d + 2'd1;
        pc_d = pc_q + 8'd1;
        if (pc_d >= part_count_i) begin
          rr = '0;
          rr.kind = dfr_pkg::KIND_DONE;
          rr.part_number = pc_d;
          rr.parts_found = pc_d;
          res_d[n_d[0]] = rr;
          n_d = n_d + 2'd1;
          phase_d = PH_SKIP;
        end else begin
          phase_d = PH_HLIT;
          lit_d   = 4'd0;
          hb_d    = '0;
          tag_d   = '0;
          chunk_d = '0;
          len_d   = '0;
          ds_d    = 1'b0;
        end
      end else begin
        res_d[n_d[0]] = rr;
        n_d = n_d + 2'd1;
      end
    end else if (phase_q != PH_SKIP) begin
      if (hb_q >= HbW'(HEADER_WINDOW)) begin
        err_d = dfr_pkg::ERR_TOO_LONG;
      end else begin
        hb_d = hb_q + HbW'(1);
        case (phase_q)
          PH_HLIT: begin
            if (lit_q >= dfr_pkg::HeadLen || byte_i != dfr_pkg::head_char(lit_q)) begin
              err_d = dfr_pkg::ERR_GRAMMAR;
            end else begin
              lit_d = lit_q + 4'd1;
              if (lit_d == dfr_pkg::HeadLen) begin
                phase_d = PH_TAG;
                ds_d = 1'b0;
              end
            end
          end
          PH_TAG: begin
            if (is_dig) begin
              if (ovf) begin
                err_d = dfr_pkg::ERR_OVERFLOW;
              end else begin
                tag_d = prod[15:0];
                ds_d = 1'b1;
              end
            end else if (byte_i == dfr_pkg::ChDash && ds_q) begin
              phase_d = PH_CHUNK;
              ds_d = 1'b0;
            end else if (byte_i == dfr_pkg::ChQuote && ds_q) begin
              phase_d = PH_CLLIT;
              lit_d = 4'd0;
            end else begin
              err_d = dfr_pkg::ERR_GRAMMAR;
            end
          end
          PH_CHUNK: begin
            if (is_dig) begin
              if (ovf) begin
                err_d = dfr_pkg::ERR_OVERFLOW;
              end else begin
                chunk_d = prod[31:0];
                ds_d = 1'b1;
              end
            end else if (byte_i == dfr_pkg::ChQuote && ds_q) begin
              phase_d = PH_CLLIT;
              lit_d = 4'd0;
            end else begin
              err_d = dfr_pkg::ERR_GRAMMAR;
            end
          end
          PH_CLLIT: begin
            if (lit_q >= dfr_pkg::ClLen || byte_i != dfr_pkg::cl_char(lit_q)) begin
              err_d = dfr_pkg::ERR_GRAMMAR;
            end else begin
              lit_d = lit_q + 4'd1;
              if (lit_d == dfr_pkg::ClLen) begin
                phase_d = PH_LEN;
                ds_d = 1'b0;
              end
            end
          end
          PH_LEN: begin
            if (is_dig) begin
              if (ovf) begin
                err_d = dfr_pkg::ERR_OVERFLOW;
              end else begin
                len_d = prod[31:0];
                ds_d = 1'b1;
              end
            end else if (byte_i == dfr_pkg::ChSlash && ds_q) begin
              phase_d = PH_CLOSE;
            end else begin
              err_d = dfr_pkg::ERR_GRAMMAR;
            end
          end
          default: begin
            // closing slash: report the header
            if (byte_i != dfr_pkg::ChSlash) begin
              err_d = dfr_pkg::ERR_GRAMMAR;
            end else begin
              rr.kind = dfr_pkg::KIND_HEADER;
              rr.part_number = pc_q;
              rr.track_tag = tag_q;
              rr.chunk_index = chunk_q;
              rr.audio_flag = (tag_q == dfr_pkg::AudioTagA) || (tag_q == dfr_pkg::AudioTagB);
              rr.payload_length = len_q;
              if (len_q == 32'd0) begin
                rr.part_end = 1'b1;
                res_d[n_d[0]] = rr;
                n_d = n_d + 2'd1;
                pc_d = pc_q + 8'd1;
                if (pc_d >= part_count_i) begin
                  rr = '0;
                  rr.kind = dfr_pkg::KIND_DONE;
                  rr.part_number = pc_d;
                  rr.parts_found = pc_d;
                  res_d[n_d[0]] = rr;
                  n_d = n_d + 2'd1;
                  phase_d = PH_SKIP;
                end else begin
                  phase_d = PH_HLIT;
                  lit_d   = 4'd0;
                  hb_d    = '0;
                  tag_d   = '0;
                  chunk_d = '0;
                  len_d   = '0;
                  ds_d    = 1'b0;
                end
              end else begin
                res_d[n_d[0]] = rr;
                n_d = n_d + 2'd1;
                left_d = len_q;
                phase_d = PH_PAY;
              end
            end
          end
        endcase
      end
    end

    // Report the first error and drop the rest of the body
    if (err_d != dfr_pkg::ERR_NONE) begin
      rr = '0;
      rr.kind = dfr_pkg::KIND_ERROR;
      rr.part_number = pc_d;
      rr.error_code = err_d;
      res_d[n_d[0]] = rr;
      n_d = n_d + 2'd1;
      phase_d = PH_SKIP;
    end

    // End of body: flag truncation, then restart at the preamble
    if (last_i) begin
      if (phase_d != PH_SKIP) begin
        rr = '0;
        rr.kind = dfr_pkg::KIND_ERROR;
        rr.part_number = pc_d;
        rr.error_code = dfr_pkg::ERR_TRUNCATED;
        res_d[n_d[0]] = rr;
        n_d = n_d + 2'd1;
      end
      phase_d = PH_PRE;
      lit_d   = 4'd0;
      hb_d    = '0;
      tag_d   = '0;
      chunk_d = '0;
      len_d   = '0;
      left_d  = '0;
      pc_d    = '0;
      ds_d    = 1'b0;
    end

    // Mark the last result of this word
    if (n_d == 2'd1) begin
      res_d[0].run_last = 1'b1;
    end else if (n_d == 2'd2) begin
      res_d[1].run_last = 1'b1;
    end
  end

  assign push_o.count  = fire_i ? n_d : 2'd0;
  assign push_o.first  = res_d[0];
  assign push_o.second = res_d[1];

  // Hold parser state, advance on each parsed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PRE;
      lit_q   <= '0;
      hb_q    <= '0;
      tag_q   <= '0;
      chunk_q <= '0;
      len_q   <= '0;
      left_q  <= '0;
      pc_q    <= '0;
      ds_q    <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      lit_q   <= lit_d;
      hb_q    <= hb_d;
      tag_q   <= tag_d;
      chunk_q <= chunk_d;
      len_q   <= len_d;
      left_q  <= left_d;
      pc_q    <= pc_d;
      ds_q    <= ds_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dfr_res_queue.sv -----
`default_nettype none

module dfr_res_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dfr_pkg::res_push_t push_i,
  input  wire logic               pop_i,
  output dfr_pkg::res_t           head_o,
  output logic                    valid_o,
  output dfr_pkg::q_stat_t        stat_o
);

  dfr_pkg::res_t                      mem_q [dfr_pkg::QueueDepth];
  logic [dfr_pkg::PtrW-1:0]           wr_q, rd_q;
  logic [dfr_pkg::LevelW-1:0]         level_q;
  logic                               pop;

  assign valid_o = level_q != '0;
  assign pop     = pop_i && valid_o;
  assign head_o  = mem_q[rd_q];

  assign stat_o.level    = level_q;
  assign stat_o.room_two = level_q <= dfr_pkg::LevelW'(dfr_pkg::QueueDepth - 2);

  // Store up to two results per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + dfr_pkg::PtrW'(1)] <= push_i.second;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_q + dfr_pkg::PtrW'(push_i.count);
      rd_q    <= rd_q + dfr_pkg::PtrW'(pop);
      level_q <= level_q + dfr_pkg::LevelW'(push_i.count) - dfr_pkg::LevelW'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/multipart_body_deframer.sv -----
// Multipart body deframer.
// Slave stream: one body byte per word in s_axis_tdata_i, s_axis_tlast_i on
// the last byte of a body. Master stream: one result per word, kind in
// m_axis_tuser_o, m_axis_tlast_o on the last result caused by one input byte.
// Each body opens with a 14-byte preamble, followed by part_count headers of
// the form //SPART-"tag[-chunk]"-CL=len// each followed by len payload bytes.
// Results: payload byte, part header, body complete, or error code.
// APB port: register 0 (address 0) is part_count, reset 1; write while idle.
// Throughput: one input byte per cycle while results drain at one per cycle;
// bytes that yield two results each are taken only as fast as the single
// output port of the four-entry result queue drains them.
// An accepted byte is held in the input register, parsed once two queue
// entries are free, and its results are registered in the result queue.
// Reset empties the input register and result queue, sets part_count to 1
// and waits for a preamble. When the receiver stalls, the queue fills and
// s_axis_tready_o drops once fewer than two entries are free; nothing is lost.
`default_nettype none

module multipart_body_deframer #(
  parameter int unsigned HEADER_WINDOW = dfr_pkg::HeaderWindow
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // body_byte
  input  wire logic [7:0]   s_axis_tdata_i,
  input  wire logic         s_axis_tlast_i,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // data_byte, part_end, track_tag, chunk_index, audio_flag, payload_length,
  // part_number, parts_found, error_code, zero fill
  output logic [111:0]      m_axis_tdata_o,
  // kind
  output logic [1:0]        m_axis_tuser_o,
  output logic              m_axis_tlast_o,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic                 in_v_q;
  logic [7:0]           in_byte_q;
  logic                 in_end_q;
  logic                 fire;
  logic                 accept;
  logic [7:0]           part_count_q;
  dfr_pkg::res_push_t   push;
  dfr_pkg::res_t        head;
  dfr_pkg::q_stat_t     q_stat;

  // Parse the held word once two queue entries are free
  assign fire            = in_v_q && q_stat.room_two;
  assign s_axis_tready_o = !in_v_q || fire;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= accept || (in_v_q && !fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= s_axis_tdata_i;
      in_end_q  <= s_axis_tlast_i;
    end
  end

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == dfr_pkg::RegPartCount) ? {24'd0, part_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_count_q <= dfr_pkg::PartCountReset;
    end else if (psel && penable && pwrite && pready
                 && paddr[2:2] == dfr_pkg::RegPartCount) begin
      part_count_q <= pwdata[7:0];
    end
  end

  dfr_parser #(
    .HEADER_WINDOW (HEADER_WINDOW)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .byte_i       (in_byte_q),
    .last_i       (in_end_q),
    .part_count_i (part_count_q),
    .push_o       (push)
  );

  dfr_res_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready_i),
    .head_o  (head),
    .valid_o (m_axis_tvalid_o),
    .stat_o  (q_stat)
  );

  // Pack the result word
  assign m_axis_tdata_o = {3'd0, head.error_code, head.parts_found, head.part_number,
                           head.payload_length, head.audio_flag, head.chunk_index,
                           head.track_tag, head.part_end, head.data_byte};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.run_last;

`ifndef ASSERT_OFF
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(q_stat.level) <= dfr_pkg::QueueDepth)
    else $error("result queue over its depth");

  a_hold_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && !fire |=> in_v_q && $stable(in_byte_q) && $stable(in_end_q))
    else $error("held input word lost");

  a_err_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && head.kind != dfr_pkg::KIND_ERROR |-> head.error_code == dfr_pkg::ERR_NONE)
    else $error("error code on a non-error result");
`endif

endmodule

`default_nettype wire
